// ===== sv/bmio_pkg.sv =====
// ============================================================================
// bmio_pkg
// Shared types and constants of the bank mapper and I/O decoder.
// ============================================================================
package bmio_pkg;

    localparam int PORT_COUNT           = 256;
    localparam int PORT_W               = 8;
    localparam int KEY_ROW_COUNT_DEF    = 10;
    localparam int KEY_ROW_MAX          = 10;
    localparam int TICKS_PER_SECOND_DEF = 64;

    localparam int KIND_W   = 3;
    localparam int ADDR_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int ROW_W    = 4;
    localparam int TARGET_W = 3;
    localparam int DADDR_W  = 22;
    localparam int LOW_W    = 14;
    localparam int TICK_W   = 7;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    localparam logic [KIND_W-1:0] KIND_MEM_RD  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MEM_WR  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PORT_RD = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PORT_WR = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TICK    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_KEY_UPD = 3'd5;

    localparam logic [TARGET_W-1:0] TGT_CODEFLASH = 3'd0;
    localparam logic [TARGET_W-1:0] TGT_RAM       = 3'd1;
    localparam logic [TARGET_W-1:0] TGT_LCD_LEFT  = 3'd2;
    localparam logic [TARGET_W-1:0] TGT_DATAFLASH = 3'd3;
    localparam logic [TARGET_W-1:0] TGT_LCD_RIGHT = 3'd4;
    localparam logic [TARGET_W-1:0] TGT_MODEM     = 3'd5;
    localparam logic [TARGET_W-1:0] TGT_NONE      = 3'd6;

    localparam logic [PORT_W-1:0] PORT_KEYBOARD = 8'h01;
    localparam logic [PORT_W-1:0] PORT_MISC2    = 8'h02;
    localparam logic [PORT_W-1:0] PORT_IRQ      = 8'h03;
    localparam logic [PORT_W-1:0] PORT_S4_PAGE  = 8'h05;
    localparam logic [PORT_W-1:0] PORT_S4_DEV   = 8'h06;
    localparam logic [PORT_W-1:0] PORT_S8_PAGE  = 8'h07;
    localparam logic [PORT_W-1:0] PORT_S8_DEV   = 8'h08;
    localparam logic [PORT_W-1:0] PORT_POWER    = 8'h28;

    localparam int IRQ_TIME_BIT = 4;
    localparam int IRQ_KEY_BIT  = 1;

    typedef struct packed {
        logic                int_possible;
        logic [ROW_W-1:0]    key_row;
        logic [BYTE_W-1:0]   data;
        logic [ADDR_W-1:0]   address;
        logic [KIND_W-1:0]   kind;
    } item_t;

    typedef struct packed {
        logic                access_error;
        logic                power_off;
        logic                interrupt_request;
        logic [BYTE_W-1:0]   read_data;
        logic [BYTE_W-1:0]   write_data;
        logic                device_write;
        logic [DADDR_W-1:0]  device_address;
        logic [TARGET_W-1:0] target;
    } result_t;

    typedef struct packed {
        logic              en;
        logic [PORT_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } pf_wr_t;

endpackage

// ===== sv/bmio_port_file.sv =====
// ============================================================================
// bmio_port_file
// 256-byte port store with per-entry valid bits; unwritten entries read zero.
// ============================================================================
module bmio_port_file (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  bmio_pkg::pf_wr_t          wr,
    input  logic                      rd_en,
    input  logic [bmio_pkg::PORT_W-1:0] rd_addr,
    output logic [bmio_pkg::BYTE_W-1:0] rd_data
);
    import bmio_pkg::*;

    logic [BYTE_W-1:0] mem [PORT_COUNT];
    logic [PORT_COUNT-1:0] valid_reg;
    logic [BYTE_W-1:0] rd_data_reg;
    logic rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== sv/bmio_exec.sv =====
// ============================================================================
// bmio_exec
// Decode of one bus event: memory map, port registers, keyboard and ticks.
// ============================================================================
module bmio_exec #(
    parameter int KEY_ROW_COUNT    = bmio_pkg::KEY_ROW_COUNT_DEF,
    parameter int TICKS_PER_SECOND = bmio_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        fire,
    input  bmio_pkg::item_t             item,
    input  logic [bmio_pkg::BYTE_W-1:0] port_rd_data,
    output bmio_pkg::result_t           result,
    output bmio_pkg::pf_wr_t            pf_wr
);
    import bmio_pkg::*;

    logic [BYTE_W-1:0] kb_sel_lo_reg, kb_sel_lo_next;
    logic [1:0]        kb_sel_hi_reg, kb_sel_hi_next;
    logic [BYTE_W-1:0] irq_en_reg, irq_en_next;
    logic [BYTE_W-1:0] s4_page_reg, s4_page_next;
    logic [3:0]        s4_dev_reg, s4_dev_next;
    logic [BYTE_W-1:0] s8_page_reg, s8_page_next;
    logic [3:0]        s8_dev_reg, s8_dev_next;
    logic [BYTE_W-1:0] pending_reg, pending_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [BYTE_W-1:0] key_rows_reg  [KEY_ROW_COUNT];
    logic [BYTE_W-1:0] key_rows_next [KEY_ROW_COUNT];

    logic [PORT_W-1:0] port;
    logic [1:0]        slot;
    logic [3:0]        dev;
    logic [BYTE_W-1:0] page;
    logic [LOW_W-1:0]  low;
    logic [BYTE_W-1:0] kb_val;
    logic [9:0]        sel;
    logic              time_done;

    assign port = item.address[PORT_W-1:0];
    assign slot = item.address[ADDR_W-1:ADDR_W-2];
    assign low  = item.address[LOW_W-1:0];
    assign sel  = {kb_sel_hi_reg, kb_sel_lo_reg};

    always_comb begin
        kb_val = '1;
        for (int i = 0; i < KEY_ROW_COUNT; i++) begin
            if (!sel[i]) begin
                kb_val = kb_val & key_rows_reg[i];
            end
        end
    end

    always_comb begin
        unique case (slot)
            2'd0: begin
                dev  = 4'(TGT_CODEFLASH);
                page = '0;
            end
            2'd1: begin
                dev  = s4_dev_reg;
                page = s4_page_reg;
            end
            2'd2: begin
                dev  = s8_dev_reg;
                page = s8_page_reg;
            end
            default: begin
                dev  = 4'(TGT_RAM);
                page = '0;
            end
        endcase
    end

    always_comb begin
        result         = '0;
        result.target  = TGT_NONE;
        pf_wr.en       = 1'b0;
        pf_wr.addr     = port;
        pf_wr.data     = item.data;
        kb_sel_lo_next = kb_sel_lo_reg;
        kb_sel_hi_next = kb_sel_hi_reg;
        irq_en_next    = irq_en_reg;
        s4_page_next   = s4_page_reg;
        s4_dev_next    = s4_dev_reg;
        s8_page_next   = s8_page_reg;
        s8_dev_next    = s8_dev_reg;
        pending_next   = pending_reg;
        tick_next      = tick_reg;
        time_done      = 1'b0;
        for (int i = 0; i < KEY_ROW_COUNT; i++) begin
            key_rows_next[i] = key_rows_reg[i];
        end

        case (item.kind)
            KIND_MEM_RD, KIND_MEM_WR: begin
                if (dev > 4'(TGT_MODEM)) begin
                    result.access_error = 1'b1;
                end else begin
                    result.target = dev[TARGET_W-1:0];
                    if (dev == 4'(TGT_LCD_LEFT) || dev == 4'(TGT_LCD_RIGHT)) begin
                        result.device_address = DADDR_W'(low);
                    end else begin
                        result.device_address = {page, low};
                    end
                    if (item.kind == KIND_MEM_WR) begin
                        result.write_data = item.data;
                        if (dev == 4'(TGT_CODEFLASH)) begin
                            result.access_error = 1'b1;
                        end else if (dev != 4'(TGT_MODEM)) begin
                            result.device_write = 1'b1;
                        end
                    end
                end
            end
            KIND_PORT_RD: begin
                if (port == PORT_KEYBOARD) begin
                    result.read_data = kb_val;
                end else if (port == PORT_IRQ) begin
                    result.read_data = pending_reg;
                end else begin
                    result.read_data = port_rd_data;
                end
            end
            KIND_PORT_WR: begin
                pf_wr.en = 1'b1;
                if (port == PORT_IRQ) begin
                    pending_next = pending_reg & item.data;
                    irq_en_next  = item.data;
                end
                if (port == PORT_POWER && item.data[0]) begin
                    result.power_off = 1'b1;
                end
                if (port == PORT_KEYBOARD) begin
                    kb_sel_lo_next = item.data;
                end
                if (port == PORT_MISC2) begin
                    kb_sel_hi_next = item.data[1:0];
                end
                if (port == PORT_S4_PAGE) begin
                    s4_page_next = item.data;
                end
                if (port == PORT_S4_DEV) begin
                    s4_dev_next = item.data[3:0];
                end
                if (port == PORT_S8_PAGE) begin
                    s8_page_next = item.data;
                end
                if (port == PORT_S8_DEV) begin
                    s8_dev_next = item.data[3:0];
                end
            end
            KIND_TICK: begin
                if (item.int_possible) begin
                    result.interrupt_request = 1'b1;
                    if (tick_reg >= TICK_W'(TICKS_PER_SECOND)) begin
                        tick_next = '0;
                        if (irq_en_reg[IRQ_TIME_BIT] && !pending_reg[IRQ_TIME_BIT]) begin
                            pending_next[IRQ_TIME_BIT] = 1'b1;
                            time_done = 1'b1;
                        end
                    end else begin
                        tick_next = tick_reg + 1'b1;
                    end
                    if (!time_done && irq_en_reg[IRQ_KEY_BIT]
                            && !pending_reg[IRQ_KEY_BIT]) begin
                        pending_next[IRQ_KEY_BIT] = 1'b1;
                    end
                end
            end
            KIND_KEY_UPD: begin
                for (int i = 0; i < KEY_ROW_COUNT; i++) begin
                    if (item.key_row == ROW_W'(i)) begin
                        key_rows_next[i] = item.data;
                    end
                end
            end
            default: begin
            end
        endcase

        pf_wr.en = pf_wr.en & fire;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kb_sel_lo_reg <= '0;
            kb_sel_hi_reg <= '0;
            irq_en_reg    <= '0;
            s4_page_reg   <= '0;
            s4_dev_reg    <= '0;
            s8_page_reg   <= '0;
            s8_dev_reg    <= '0;
            pending_reg   <= '0;
            tick_reg      <= '0;
            for (int i = 0; i < KEY_ROW_COUNT; i++) begin
                key_rows_reg[i] <= '1;
            end
        end else if (fire) begin
            kb_sel_lo_reg <= kb_sel_lo_next;
            kb_sel_hi_reg <= kb_sel_hi_next;
            irq_en_reg    <= irq_en_next;
            s4_page_reg   <= s4_page_next;
            s4_dev_reg    <= s4_dev_next;
            s8_page_reg   <= s8_page_next;
            s8_dev_reg    <= s8_dev_next;
            pending_reg   <= pending_next;
            tick_reg      <= tick_next;
            for (int i = 0; i < KEY_ROW_COUNT; i++) begin
                key_rows_reg[i] <= key_rows_next[i];
            end
        end
    end

endmodule

// ===== sv/bank_mapper_io_decoder_unit.sv =====
// ============================================================================
// bank_mapper_io_decoder_unit
// Memory bank mapper and I/O port decoder of a small Z80 handheld.
//
//  channel | dir | ports                 | payload
//  --------+-----+-----------------------+-----------------------------------
//  s_      | in  | tvalid tready tdata   | tuser: kind; tdata: address, data,
//          |     | tuser                 |   key_row, int_possible
//  m_      | out | tvalid tready tdata   | tdata: target .. access_error
//
// One item per cycle sustained while m_ does not stall; each item passes the
// input register (with port-store read) and then the result register.
// The port store read is registered at accept; a write from the item ahead
// is forwarded. Reset clears all state at once, no clearing pass.
// A stall on m_ holds the result and then the input register.
// ============================================================================
module bank_mapper_io_decoder_unit #(
    parameter int KEY_ROW_COUNT    = bmio_pkg::KEY_ROW_COUNT_DEF,
    parameter int TICKS_PER_SECOND = bmio_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] address, [23:16] data, [27:24] key_row, [28] int_possible
    input  logic [bmio_pkg::S_TDATA_W-1:0] s_tdata,
    // [2:0] kind
    input  logic [bmio_pkg::KIND_W-1:0]    s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [2:0] target, [24:3] device_address, [25] device_write,
    // [33:26] write_data, [41:34] read_data, [42] interrupt_request,
    // [43] power_off, [44] access_error
    output logic [bmio_pkg::M_TDATA_W-1:0] m_tdata
);
    import bmio_pkg::*;

    logic              s1_valid_reg;
    item_t             s1_item_reg;
    logic              fwd_hit_reg;
    logic [BYTE_W-1:0] fwd_data_reg;
    logic              m_valid_reg;
    result_t           m_data_reg;

    item_t             in_item;
    logic              accept;
    logic              fire;
    logic [BYTE_W-1:0] pf_rd_data;
    logic [BYTE_W-1:0] port_val;
    result_t           result;
    pf_wr_t            pf_wr;

    assign in_item.kind         = s_tuser;
    assign in_item.address      = s_tdata[15:0];
    assign in_item.data         = s_tdata[23:16];
    assign in_item.key_row      = s_tdata[27:24];
    assign in_item.int_possible = s_tdata[28];

    assign fire     = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || fire;
    assign accept   = s_tvalid && s_tready;
    assign port_val = fwd_hit_reg ? fwd_data_reg : pf_rd_data;

    bmio_port_file u_port_file (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (pf_wr),
        .rd_en   (accept),
        .rd_addr (in_item.address[PORT_W-1:0]),
        .rd_data (pf_rd_data)
    );

    bmio_exec #(
        .KEY_ROW_COUNT    (KEY_ROW_COUNT),
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_exec (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .item         (s1_item_reg),
        .port_rd_data (port_val),
        .result       (result),
        .pf_wr        (pf_wr)
    );

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg  <= in_item;
            fwd_data_reg <= pf_wr.data;
        end
        if (fire) begin
            m_data_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= pf_wr.en && (pf_wr.addr == in_item.address[PORT_W-1:0]);
            end else if (fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_data_reg);

endmodule
